[rtl/pfs_pkg.sv]
// Package for the streaming prefix-function block.
// Field widths and the default string capacity; no dependencies.
`default_nettype none

package pfs_pkg;

    localparam int SYMBOL_W    = 8;
    localparam int PREFIX_W    = 10;
    localparam int MAX_LEN_DEF = 1024;

endpackage

`default_nettype wire

[rtl/pfs_store.sv]
// Symbol and border memories, one write port, synchronous (registered) read.
// Depends on pfs_pkg for the symbol width.
`default_nettype none

module pfs_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                         i_clk,
    input  wire logic [AW-1:0]                i_rd_addr,
    output logic      [pfs_pkg::SYMBOL_W-1:0] o_rd_symbol,
    output logic      [AW-1:0]                o_rd_border,
    input  wire logic                         i_wr_en,
    input  wire logic [AW-1:0]                i_wr_addr,
    input  wire logic [pfs_pkg::SYMBOL_W-1:0] i_wr_symbol,
    input  wire logic [AW-1:0]                i_wr_border
);
    import pfs_pkg::*;

    logic [SYMBOL_W-1:0] r_symbol_mem [DEPTH];
    logic [AW-1:0]       r_border_mem [DEPTH];
    logic [AW-1:0]       border_addr;

    // border of the candidate prefix is kept one entry below it
    assign border_addr = AW'(i_rd_addr - 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_symbol_mem[i_wr_addr] <= i_wr_symbol;
            r_border_mem[i_wr_addr] <= i_wr_border;
        end
        o_rd_symbol <= r_symbol_mem[i_rd_addr];
        o_rd_border <= r_border_mem[border_addr];
    end

endmodule

`default_nettype wire

[rtl/pfs_ctrl.sv]
// Sequencer for the prefix function: candidate compare, fallback, result register.
// Depends on pfs_pkg; drives the read and write ports of pfs_store.
`default_nettype none

module pfs_ctrl #(
    parameter int MAX_LEN = 1024,
    parameter int AW      = 10,
    parameter int PW      = 11
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [pfs_pkg::SYMBOL_W-1:0] i_symbol,
    input  wire logic                         i_last,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [pfs_pkg::PREFIX_W-1:0] o_prefix_length,
    output logic                              o_overflow,
    output logic                              o_end_of_string,
    output logic      [AW-1:0]                o_rd_addr,
    input  wire logic [pfs_pkg::SYMBOL_W-1:0] i_rd_symbol,
    input  wire logic [AW-1:0]                i_rd_border,
    output logic                              o_wr_en,
    output logic      [AW-1:0]                o_wr_addr,
    output logic      [pfs_pkg::SYMBOL_W-1:0] o_wr_symbol,
    output logic      [AW-1:0]                o_wr_border
);
    import pfs_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_EMIT} t_state;

    t_state              r_state, n_state;
    logic [PW-1:0]       r_pos, n_pos;
    logic [AW-1:0]       r_match, n_match;
    logic [SYMBOL_W-1:0] r_sym, n_sym;
    logic                r_last, n_last;
    logic [AW-1:0]       r_cand, n_cand;
    logic [AW-1:0]       r_len, n_len;
    logic                r_ovf, n_ovf;
    logic                r_wr, n_wr;
    logic                r_out_valid, n_out_valid;
    logic [PREFIX_W-1:0] r_out_len, n_out_len;
    logic                r_out_ovf, n_out_ovf;
    logic                r_out_eos, n_out_eos;

    logic [AW-1:0] init_cand;
    logic [AW-1:0] fb_cand;
    logic          sym_hit;
    logic          emit_fire;

    assign init_cand = (PW'(r_match) >= r_pos) ? '0 : r_match;
    assign fb_cand   = (i_rd_border < r_cand) ? i_rd_border : '0;
    assign sym_hit   = (i_rd_symbol == r_sym);
    assign emit_fire = (r_state == S_EMIT) && (!r_out_valid || !i_stall);

    // idle reads the first candidate, compare state reads the fallback one
    assign o_rd_addr = (r_state == S_CMP) ? fb_cand : init_cand;

    assign o_wr_en     = emit_fire && r_wr;
    assign o_wr_addr   = r_pos[AW-1:0];
    assign o_wr_symbol = r_sym;
    assign o_wr_border = r_len;

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_prefix_length = r_out_len;
    assign o_overflow      = r_out_ovf;
    assign o_end_of_string = r_out_eos;

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_match     = r_match;
        n_sym       = r_sym;
        n_last      = r_last;
        n_cand      = r_cand;
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_wr        = r_wr;
        n_out_valid = r_out_valid && i_stall;
        n_out_len   = r_out_len;
        n_out_ovf   = r_out_ovf;
        n_out_eos   = r_out_eos;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sym  = i_symbol;
                    n_last = i_last;
                    n_cand = init_cand;
                    n_len  = '0;
                    if (r_pos == PW'(MAX_LEN)) begin
                        n_ovf   = 1'b1;
                        n_wr    = 1'b0;
                        n_state = S_EMIT;
                    end else if (r_pos == '0) begin
                        n_ovf   = 1'b0;
                        n_wr    = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_ovf   = 1'b0;
                        n_wr    = 1'b1;
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                if (sym_hit) begin
                    n_len   = AW'(r_cand + 1'b1);
                    n_state = S_EMIT;
                end else if (r_cand == '0) begin
                    n_len   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_cand = fb_cand;
                end
            end
            S_EMIT: begin
                if (emit_fire) begin
                    n_out_valid = 1'b1;
                    n_out_len   = PREFIX_W'(r_len);
                    n_out_ovf   = r_ovf;
                    n_out_eos   = r_last;
                    n_state     = S_IDLE;
                    if (r_last) begin
                        n_pos   = '0;
                        n_match = '0;
                    end else if (!r_ovf) begin
                        n_pos   = PW'(r_pos + 1'b1);
                        n_match = r_len;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_match     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_match     <= n_match;
            r_out_valid <= n_out_valid;
        end
        r_sym     <= n_sym;
        r_last    <= n_last;
        r_cand    <= n_cand;
        r_len     <= n_len;
        r_ovf     <= n_ovf;
        r_wr      <= n_wr;
        r_out_len <= n_out_len;
        r_out_ovf <= n_out_ovf;
        r_out_eos <= n_out_eos;
    end

endmodule

`default_nettype wire

[rtl/prefix_function_stream.sv]
// Streaming prefix function: one byte in, its longest border length out.
// A byte is taken in idle; the compare state then repeats once per fallback step, and the emit
// state loads the result register, waiting while a held result is stalled. The first byte of a string
// and an overflowing byte skip the compare state. No new byte is taken until the result is emitted.
// Reset clears state, position, match length and output valid; stores are not cleared.
// Depends on pfs_pkg, pfs_store, pfs_ctrl.
`default_nettype none

module prefix_function_stream #(
    parameter int MAX_LEN = pfs_pkg::MAX_LEN_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [pfs_pkg::SYMBOL_W-1:0] i_symbol,
    input  wire logic                         i_last,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [pfs_pkg::PREFIX_W-1:0] o_prefix_length,
    output logic                              o_overflow,
    output logic                              o_end_of_string
);
    import pfs_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int PW = $clog2(MAX_LEN + 1);

    logic [AW-1:0]       rd_addr;
    logic [SYMBOL_W-1:0] rd_symbol;
    logic [AW-1:0]       rd_border;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [SYMBOL_W-1:0] wr_symbol;
    logic [AW-1:0]       wr_border;

    pfs_store #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rd_addr   (rd_addr),
        .o_rd_symbol (rd_symbol),
        .o_rd_border (rd_border),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_symbol (wr_symbol),
        .i_wr_border (wr_border)
    );

    pfs_ctrl #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW),
        .PW      (PW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_symbol        (i_symbol),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_prefix_length (o_prefix_length),
        .o_overflow      (o_overflow),
        .o_end_of_string (o_end_of_string),
        .o_rd_addr       (rd_addr),
        .i_rd_symbol     (rd_symbol),
        .i_rd_border     (rd_border),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_symbol     (wr_symbol),
        .o_wr_border     (wr_border)
    );

    // an overflowing byte always reports zero
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_prefix_length == '0)
        else $error("overflow result with nonzero prefix length");

    // block is busy in the cycle after an input transfer
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_valid && !o_stall |=> o_stall)
        else $error("input taken again without processing");

    // at most one store write per item, never back to back
    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> !wr_en)
        else $error("store written in consecutive cycles");

    // writes stay inside the store and carry a border no longer than its position
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (PW'(wr_addr) < PW'(MAX_LEN)) && (wr_border <= wr_addr))
        else $error("store write out of range");

endmodule

`default_nettype wire
